// ----- design/mrac_pkg.sv -----
// Package: shared types and constants for the two-wheel MRAC speed controller.
package mrac_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ADAPT_SHIFT = 24 + FRAC_BITS;

    localparam logic [2:0] REG_MODEL_POLE = 3'd0;
    localparam logic [2:0] REG_ADAPT_GAIN = 3'd1;
    localparam logic [2:0] REG_ERROR_DEADBAND = 3'd2;
    localparam logic [2:0] REG_DRIVE_DEADZONE = 3'd3;
    localparam logic [2:0] REG_FF_GAIN_START = 3'd4;
    localparam logic [2:0] REG_FF_GAIN_LIMIT = 3'd5;
    localparam logic [2:0] REG_REF_AMPLITUDE = 3'd6;
    localparam logic [2:0] REG_REF_HALF_PERIOD = 3'd7;

    localparam logic signed [15:0] FB_GAIN_LIMIT = 16'(7 <<< (FRAC_BITS - 1));
    localparam logic signed [19:0] FF_GAIN_START_RESET = 20'sd40960;

    typedef struct packed {
        logic [15:0] model_pole;
        logic [15:0] adapt_gain;
        logic [15:0] error_deadband;
        logic [19:0] drive_deadzone;
        logic signed [19:0] ff_gain_start;
        logic [18:0] ff_gain_limit;
        logic [17:0] ref_amplitude;
        logic [15:0] ref_half_period;
    } cfg_t;

    // datapath step codes
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_MODEL_A,
        OP_MODEL_B,
        OP_MODEL_SAT,
        OP_ERR,
        OP_AE,
        OP_D1,
        OP_D2,
        OP_GAINS,
        OP_U_A,
        OP_U_B,
        OP_U_OUT
    } op_t;

    typedef struct packed {
        logic start;
        op_t op;
        logic wheel;
    } cmd_t;

    // round to nearest, ties away from zero
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int s);
        logic [63:0] m;
        begin
            m = v[63] ? 64'(-v) : 64'(v);
            m = (m + (64'd1 << (s - 1))) >> s;
            rshr = v[63] ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic signed [63:0] sat(input logic signed [63:0] v, input int w);
        logic signed [63:0] hi;
        begin
            hi = (64'sd1 <<< (w - 1)) - 64'sd1;
            if (v > hi) sat = hi;
            else if (v < -hi - 64'sd1) sat = -hi - 64'sd1;
            else sat = v;
        end
    endfunction

endpackage

// ----- design/mrac_datapath.sv -----
// Datapath: one shared multiplier, accumulator and per-wheel state registers.
module mrac_datapath import mrac_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  cmd_t cmd,
    input  logic signed [19:0] speed_left,
    input  logic signed [19:0] speed_right,
    output logic signed [23:0] drive_left,
    output logic signed [23:0] drive_right,
    output logic signed [18:0] reference_now
);

    logic signed [19:0] model_reg [2];
    logic signed [19:0] ff_reg [2];
    logic signed [15:0] fb_reg [2];
    logic [16:0] tick_reg;
    logic signed [18:0] r_reg;
    logic signed [19:0] sl_reg, sr_reg;
    logic signed [63:0] acc_reg;
    logic signed [58:0] prod;
    logic signed [20:0] e_reg;
    logic signed [37:0] ae_reg;
    logic signed [19:0] d1_reg;
    logic signed [20:0] d2_reg;
    logic signed [23:0] dl_reg, dr_reg;

    logic signed [19:0] spd;
    logic signed [37:0] ma;
    logic signed [20:0] mb;
    logic [16:0] half;
    logic signed [20:0] diff, db;
    logic signed [63:0] t1, t2, u, dz;
    logic signed [19:0] lim1;
    logic w;

    assign w = cmd.wheel;
    assign spd = w ? sr_reg : sl_reg;
    assign half = (cfg.ref_half_period == 16'd0) ? 17'd1 : {1'b0, cfg.ref_half_period};
    assign db = 21'(cfg.error_deadband);
    assign lim1 = 20'(cfg.ff_gain_limit);
    assign dz = 64'($signed({1'b0, cfg.drive_deadzone}));
    assign diff = 21'(spd) - 21'(model_reg[w]);

    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_MODEL_A: begin
                ma = 38'($signed({1'b0, cfg.model_pole}));
                mb = 21'(model_reg[w]);
            end
            OP_MODEL_B: begin
                ma = 38'sd65536 - 38'($signed({1'b0, cfg.model_pole}));
                mb = 21'(r_reg);
            end
            OP_AE: begin
                ma = 38'($signed({1'b0, cfg.adapt_gain}));
                mb = e_reg;
            end
            OP_D1: begin
                ma = ae_reg;
                mb = 21'(r_reg);
            end
            OP_D2: begin
                ma = ae_reg;
                mb = 21'(spd);
            end
            OP_U_A: begin
                ma = 38'(ff_reg[w]);
                mb = 21'(r_reg);
            end
            OP_U_B: begin
                ma = 38'(fb_reg[w]);
                mb = 21'(spd);
            end
            default: ;
        endcase
        prod = 59'(ma) * 59'(mb);
    end

    always_comb begin
        t1 = 64'(ff_reg[w]) + 64'(d1_reg);
        t2 = 64'(fb_reg[w]) + 64'(d2_reg);
        if ((ff_reg[w] >= lim1 && d1_reg > 0) || (ff_reg[w] <= -lim1 && d1_reg < 0))
            t1 = 64'(ff_reg[w]);
        if ((fb_reg[w] >= FB_GAIN_LIMIT && d2_reg > 0) ||
            (fb_reg[w] <= -FB_GAIN_LIMIT && d2_reg < 0))
            t2 = 64'(fb_reg[w]);
        u = rshr(acc_reg - 64'(prod), FRAC_BITS);
        if (u > 0) begin
            if (u <= dz) u = dz;
        end else if (u < 0) begin
            if (u >= -dz) u = -dz;
        end
        u = sat(u, 24);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            for (int k = 0; k < 2; k++) begin
                model_reg[k] <= '0;
                ff_reg[k] <= FF_GAIN_START_RESET;
                fb_reg[k] <= '0;
            end
        end else begin
            case (cmd.op)
                OP_LOAD: if (cmd.start) begin
                    sl_reg <= speed_left;
                    sr_reg <= speed_right;
                    r_reg <= (tick_reg < half) ? 19'($signed({1'b0, cfg.ref_amplitude}))
                                               : -19'($signed({1'b0, cfg.ref_amplitude}));
                    tick_reg <= (tick_reg + 17'd1 >= {half[15:0], 1'b0}) ? 17'd0
                                                                        : tick_reg + 17'd1;
                end
                OP_MODEL_A: acc_reg <= 64'(prod);
                OP_MODEL_B: acc_reg <= acc_reg + 64'(prod);
                OP_MODEL_SAT: model_reg[w] <= 20'(sat(rshr(acc_reg, 16), 20));
                OP_ERR: begin
                    if (diff > db) e_reg <= diff - db;
                    else if (diff < -db) e_reg <= diff + db;
                    else e_reg <= '0;
                end
                OP_AE: ae_reg <= 38'(prod);
                OP_D1: d1_reg <= 20'(-rshr(64'(prod), ADAPT_SHIFT));
                OP_D2: d2_reg <= 21'(rshr(64'(prod), ADAPT_SHIFT));
                OP_GAINS: begin
                    ff_reg[w] <= 20'(sat(t1, 20));
                    fb_reg[w] <= 16'(sat(t2, 16));
                end
                OP_U_A: acc_reg <= 64'(prod);
                OP_U_B: if (w) dr_reg <= 24'(u); else dl_reg <= 24'(u);
                default: ;
            endcase
        end
    end

    assign drive_left = dl_reg;
    assign drive_right = dr_reg;
    assign reference_now = r_reg;

endmodule

// ----- design/mrac_ctrl.sv -----
// Controller: sequences the datapath steps for both wheels of one request.
module mrac_ctrl import mrac_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_fire,
    input  logic out_fire,
    output logic in_ready,
    output logic out_valid,
    output cmd_t cmd
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

    state_t state_reg;
    op_t op_reg;
    logic wheel_reg;

    always_comb begin
        in_ready = (state_reg == S_IDLE) || (state_reg == S_DONE && out_fire);
        out_valid = (state_reg == S_DONE);
        cmd.start = in_fire;
        cmd.op = (state_reg == S_RUN) ? op_reg : OP_LOAD;
        cmd.wheel = wheel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg <= OP_MODEL_A;
            wheel_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                S_IDLE, S_DONE: begin
                    if (state_reg == S_DONE && out_fire) state_reg <= S_IDLE;
                    if (in_fire) begin
                        state_reg <= S_RUN;
                        op_reg <= OP_MODEL_A;
                        wheel_reg <= 1'b1;
                    end
                end
                S_RUN: begin
                    if (op_reg == OP_U_B) begin
                        op_reg <= OP_MODEL_A;
                        if (wheel_reg) wheel_reg <= 1'b0;
                        else state_reg <= S_DONE;
                    end else begin
                        op_reg <= op_t'(op_reg + 4'd1);
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- design/mrac_two_wheel_speed_control.sv -----
// Top level: two-wheel MRAC speed controller with configuration registers.
// The result of a request is offered once the datapath has run its steps:
// a single shared multiplier runs ten steps per wheel, right wheel then left.
// A new request is taken in the cycle its predecessor's result is taken, so
// requests never overlap. Register 4 (start gain) returns to its default at
// every reset; feedforward gains reset to that default, not to register 4.
module mrac_two_wheel_speed_control import mrac_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [19:0] cfg_data,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [39:0] s_tdata,   // speed_left[19:0], speed_right[39:20]
    output logic m_tvalid,
    input  logic m_tready,
    output logic [71:0] m_tdata    // drive_left[23:0], drive_right[47:24],
                                   // reference_now[66:48], zeros
);

    cfg_t cfg_reg;
    cmd_t cmd;
    logic signed [23:0] dl, dr;
    logic signed [18:0] rn;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.model_pole <= 16'd8869;
            cfg_reg.adapt_gain <= 16'd16777;
            cfg_reg.error_deadband <= 16'd614;
            cfg_reg.drive_deadzone <= 20'd81920;
            cfg_reg.ff_gain_start <= FF_GAIN_START_RESET;
            cfg_reg.ff_gain_limit <= 19'd102400;
            cfg_reg.ref_amplitude <= 18'd20480;
            cfg_reg.ref_half_period <= 16'd100;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODEL_POLE: cfg_reg.model_pole <= cfg_data[15:0];
                REG_ADAPT_GAIN: cfg_reg.adapt_gain <= cfg_data[15:0];
                REG_ERROR_DEADBAND: cfg_reg.error_deadband <= cfg_data[15:0];
                REG_DRIVE_DEADZONE: cfg_reg.drive_deadzone <= cfg_data;
                REG_FF_GAIN_START: cfg_reg.ff_gain_start <= cfg_data;
                REG_FF_GAIN_LIMIT: cfg_reg.ff_gain_limit <= cfg_data[18:0];
                REG_REF_AMPLITUDE: cfg_reg.ref_amplitude <= cfg_data[17:0];
                REG_REF_HALF_PERIOD: cfg_reg.ref_half_period <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mrac_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
        .in_ready(s_tready), .out_valid(m_tvalid), .cmd(cmd)
    );

    mrac_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .cmd(cmd),
        .speed_left(s_tdata[19:0]), .speed_right(s_tdata[39:20]),
        .drive_left(dl), .drive_right(dr), .reference_now(rn)
    );

    assign m_tdata = {5'd0, rn, dr, dl};

endmodule

// ----- test/mrac_checker.sv -----
// Checker: predicts MRAC drive outputs and compares them against the result stream.
`timescale 1ns / 100ps
module mrac_checker import mrac_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          fails,
    output int          pending,
    output int          results_seen
);

    typedef struct packed {
        logic signed [23:0] drive_left;
        logic signed [23:0] drive_right;
        logic signed [18:0] reference_now;
    } drive_t;

    drive_t expected_drives[$];

    longint pole, adapt, deadband, deadzone, ff_start, ff_limit, amplitude, half_period;
    longint model_spd[2];
    longint ff_gain[2];
    longint fb_gain[2];
    longint ticks;

    function automatic longint round_shift(longint v, int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp_bits(longint v, int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint wheel_drive(int k, longint spd, longint r);
        longint m, e, d1, d2, u;
        m = pole * model_spd[k] + (65536 - pole) * r;
        model_spd[k] = clamp_bits(round_shift(m, 16), 20);
        e = spd - model_spd[k];
        if (e > deadband) e = e - deadband;
        else if (e < -deadband) e = e + deadband;
        else e = 0;
        d1 = -round_shift(adapt * r * e, ADAPT_SHIFT);
        d2 = round_shift(adapt * spd * e, ADAPT_SHIFT);
        if ((ff_gain[k] >= ff_limit && d1 > 0) || (ff_gain[k] <= -ff_limit && d1 < 0))
            d1 = 0;
        if ((fb_gain[k] >= longint'(FB_GAIN_LIMIT) && d2 > 0) ||
            (fb_gain[k] <= -longint'(FB_GAIN_LIMIT) && d2 < 0))
            d2 = 0;
        ff_gain[k] = clamp_bits(ff_gain[k] + d1, 20);
        fb_gain[k] = clamp_bits(fb_gain[k] + d2, 16);
        u = round_shift(ff_gain[k] * r - fb_gain[k] * spd, FRAC_BITS);
        if (u > 0) begin
            if (u <= deadzone) u = deadzone;
        end else if (u < 0) begin
            if (u >= -deadzone) u = -deadzone;
        end
        return clamp_bits(u, 24);
    endfunction

    function automatic drive_t control_tick(logic signed [19:0] sl, logic signed [19:0] sr);
        drive_t d;
        longint half, r;
        half = (half_period == 0) ? 1 : half_period;
        r = (ticks < half) ? amplitude : -amplitude;
        ticks++;
        if (ticks >= 2 * half) ticks = 0;
        d.drive_right = 24'(wheel_drive(1, longint'(sr), r));
        d.drive_left = 24'(wheel_drive(0, longint'(sl), r));
        d.reference_now = 19'(r);
        return d;
    endfunction

    always @(posedge aclk) begin
        drive_t got, want;
        if (!aresetn) begin
            pole = 8869; adapt = 16777; deadband = 614; deadzone = 81920;
            ff_start = 40960; ff_limit = 102400; amplitude = 20480; half_period = 100;
            for (int k = 0; k < 2; k++) begin
                model_spd[k] = 0;
                ff_gain[k] = ff_start;
                fb_gain[k] = 0;
            end
            ticks = 0;
            expected_drives.delete();
            fails = 0;
            results_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODEL_POLE: pole = cfg_data[15:0];
                    REG_ADAPT_GAIN: adapt = cfg_data[15:0];
                    REG_ERROR_DEADBAND: deadband = cfg_data[15:0];
                    REG_DRIVE_DEADZONE: deadzone = cfg_data;
                    REG_FF_GAIN_START: ff_start = longint'($signed(cfg_data));
                    REG_FF_GAIN_LIMIT: ff_limit = cfg_data[18:0];
                    REG_REF_AMPLITUDE: amplitude = cfg_data[17:0];
                    REG_REF_HALF_PERIOD: half_period = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.drive_left = m_tdata[23:0];
                got.drive_right = m_tdata[47:24];
                got.reference_now = m_tdata[66:48];
                if (expected_drives.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] unexpected result %h", $time, m_tdata);
                end else begin
                    want = expected_drives.pop_front();
                    if (got.drive_left !== want.drive_left ||
                        got.drive_right !== want.drive_right ||
                        got.reference_now !== want.reference_now ||
                        m_tdata[71:67] !== 5'd0) begin
                        fails++;
                        if (fails <= 10)
                            $display("[%0t] mismatch: exp L=%0d R=%0d ref=%0d got L=%0d R=%0d ref=%0d pad=%h",
                                $time, want.drive_left, want.drive_right, want.reference_now,
                                got.drive_left, got.drive_right, got.reference_now,
                                m_tdata[71:67]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_drives.push_back(control_tick(s_tdata[19:0], s_tdata[39:20]));
        end
        pending = expected_drives.size();
    end

endmodule

// ----- test/tb.sv -----
// Testbench top: drives speed requests and register writes into the MRAC controller.
`timescale 1ns / 100ps
module tb import mrac_pkg::*;;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // speed_left[19:0], speed_right[39:20]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // drive_left[23:0], drive_right[47:24], reference_now[66:48]

    int fails, pending, results_seen;
    int requests_sent;
    int idle_cycles;
    bit hold_results;
    longint cur_amp;

    localparam int STALL_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    mrac_two_wheel_speed_control dut (.*);

    mrac_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_tready <= 0;
                repeat (STALL_CYCLES) @(posedge aclk);
                hold_results = 0;
            end else if ($urandom_range(0, 99) < 30) begin
                m_tready <= 0;
                repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40))
                    @(posedge aclk);
            end else begin
                m_tready <= 1;
                if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 30)) @(posedge aclk);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 0;
    endtask

    task automatic send_speeds(logic signed [19:0] sl, logic signed [19:0] sr);
        s_tvalid <= 1;
        s_tdata <= {sr, sl};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        requests_sent++;
        if ($urandom_range(0, 99) < 35) begin
            s_tvalid <= 0;
            repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(15, 60))
                @(posedge aclk);
        end
    endtask

    task automatic drain;
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic load_settings(logic [15:0] pole, logic [15:0] adapt, logic [15:0] band,
                                 logic [19:0] zone, logic [19:0] start, logic [18:0] limit,
                                 logic [17:0] amp, logic [15:0] half);
        write_reg(REG_MODEL_POLE, 20'(pole));
        write_reg(REG_ADAPT_GAIN, 20'(adapt));
        write_reg(REG_ERROR_DEADBAND, 20'(band));
        write_reg(REG_DRIVE_DEADZONE, zone);
        write_reg(REG_FF_GAIN_START, start);
        write_reg(REG_FF_GAIN_LIMIT, 20'(limit));
        write_reg(REG_REF_AMPLITUDE, 20'(amp));
        write_reg(REG_REF_HALF_PERIOD, 20'(half));
        cur_amp = amp;
    endtask

    function automatic logic signed [19:0] pick_speed();
        longint v;
        case ($urandom_range(0, 9))
            0, 1, 2: return 20'($urandom);
            8: return 20'($signed($urandom_range(0, 4000)) - 2000);
            9: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
            default: begin
                v = ($urandom_range(0, 1) ? cur_amp : -cur_amp)
                    + longint'($urandom_range(0, 8000)) - 4000;
                if (v > 524287) v = 524287;
                if (v < -524288) v = -524288;
                return 20'(v);
            end
        endcase
    endfunction

    initial begin
        logic signed [19:0] corner[6];
        aresetn = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        hold_results = 0;
        requests_sent = 0;
        cur_amp = 20480;
        corner = '{20'sh7FFFF, 20'sh80000, 20'sd0, 20'sd1, -20'sd1, 20'sd20480};
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // corners under reset settings, including deadband edges
        foreach (corner[i]) send_speeds(corner[i], corner[5 - i]);
        send_speeds(20'sd614, -20'sd614);
        send_speeds(20'sd615, -20'sd615);
        send_speeds(20'sd21094, 20'sd19866);
        for (int i = 0; i < 7; i++) send_speeds(pick_speed(), pick_speed());
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: load_settings(16'hFFFF, 16'hFFFF, 16'd0, 20'd0, 20'h7FFFF, 19'h7FFFF,
                                 18'h3FFFF, 16'd1);
                1: load_settings(16'd0, 16'd0, 16'hFFFF, 20'hFFFFF, 20'h80000, 19'd0,
                                 18'd0, 16'd0);
                2: load_settings(16'd8869, 16'hFFFF, 16'd100, 20'd4096, 20'd0, 19'd20000,
                                 18'd20480, 16'd3);
                6: load_settings(16'($urandom), 16'($urandom), 16'($urandom_range(0, 2000)),
                                 20'($urandom), 20'($urandom), 19'($urandom),
                                 18'($urandom), 16'hFFFF);
                default: load_settings(16'($urandom), 16'($urandom),
                                 16'($urandom_range(0, 2000)),
                                 20'($urandom_range(0, 200000)), 20'($urandom),
                                 19'($urandom_range(0, 150000)),
                                 18'($urandom_range(0, 262143)),
                                 16'($urandom_range(1, 20)));
            endcase
            for (int i = 0; i < 148; i++) begin
                if (ph == 3 && i == 40) hold_results = 1;
                send_speeds(pick_speed(), pick_speed());
            end
            drain();
        end

        $display("%0d speed requests sent, %0d results checked over 8 register settings",
                 requests_sent, results_seen);
        $display("settings included pole/gain/amplitude extremes, half period 0, 1 and max");
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/mrac_pkg.sv
design/mrac_datapath.sv
design/mrac_ctrl.sv
design/mrac_two_wheel_speed_control.sv
test/mrac_checker.sv
test/tb.sv
